### design/rppp_pkg.sv
`default_nettype none
package rppp_pkg;

  // Frame buffer size in bytes, per plane
  localparam int BUFFER_BYTES = 1024;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);

  // Queue between the classifying front and the memory back
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Empirical offset of rotations 1 and 2 (first quarter turn and half turn)
  localparam int ROT_OFFSET = 7;

  // Input commands
  localparam logic [1:0] CMD_PLOT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ROTATION    = 3'd0;
  localparam logic [2:0] REG_FLIP_MODE   = 3'd1;
  localparam logic [2:0] REG_PANEL_W     = 3'd2;
  localparam logic [2:0] REG_PANEL_H     = 3'd3;
  localparam logic [2:0] REG_DRAW_W      = 3'd4;
  localparam logic [2:0] REG_DRAW_H      = 3'd5;
  localparam logic [2:0] REG_PAGE_HEIGHT = 3'd6;
  localparam logic [2:0] REG_PAGE_INDEX  = 3'd7;

  // Configuration reset values
  localparam logic [1:0] ROTATION_RST    = 2'd0;
  localparam logic [1:0] FLIP_MODE_RST   = 2'd0;
  localparam logic [8:0] PANEL_W_RST     = 9'd128;
  localparam logic [8:0] PANEL_H_RST     = 9'd250;
  localparam logic [8:0] DRAW_W_RST      = 9'd122;
  localparam logic [8:0] DRAW_H_RST      = 9'd250;
  localparam logic [8:0] PAGE_HEIGHT_RST = 9'd10;
  localparam logic [7:0] PAGE_INDEX_RST  = 8'd0;

  // Operation the back carries out for one queued word
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PLOT,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_pos;
    logic [1:0]        color;
    logic [7:0]        black;
    logic [7:0]        red;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_FINISH
  } bk_state_t;

endpackage
`default_nettype wire

### design/rppp_ram.sv
`default_nettype none
module rppp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### design/rppp_fifo.sv
`default_nettype none
module rppp_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rppp_pkg::item_t     push_item,
  input  wire logic                pop,
  output rppp_pkg::item_t          head,
  output rppp_pkg::q_status_t      status
);

  rppp_pkg::item_t                     slots [rppp_pkg::QUEUE_DEPTH];
  logic [rppp_pkg::QPTR_W-1:0]         wr_ptr;
  logic [rppp_pkg::QPTR_W-1:0]         rd_ptr;
  logic [rppp_pkg::QCNT_W-1:0]         count;

  // Store words at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == rppp_pkg::QCNT_W'(rppp_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire

### design/rppp_front.sv
`default_nettype none
module rppp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [8:0]        cfg_data,
  input  wire logic              take,
  input  wire logic [1:0]        cmd,
  input  wire logic signed [10:0] x_coord,
  input  wire logic signed [10:0] y_coord,
  input  wire logic [1:0]        pixel_color,
  input  wire logic [9:0]        byte_address,
  input  wire logic [7:0]        black_in,
  input  wire logic [7:0]        red_in,
  output logic                   push,
  output rppp_pkg::item_t        push_item,
  output logic [2:0]             inflight
);

  // Fields that ride along the stages unchanged
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] color;
    logic [9:0] baddr;
    logic [7:0] black;
    logic [7:0] red;
  } carry_t;

  // Configuration registers
  logic [1:0] rotation;
  logic [1:0] flip_mode;
  logic [8:0] panel_w;
  logic [8:0] panel_h;
  logic [8:0] draw_w;
  logic [8:0] draw_h;
  logic [8:0] page_height;
  logic [7:0] page_index;

  // Stage registers
  logic               v0, v1, v2, v3;
  carry_t             c0, c1, c2, c3;
  logic signed [10:0] x0, y0;
  logic signed [12:0] px1, py1, px2, py2;
  logic [16:0]        top1;
  logic signed [18:0] top2, bottom2;
  logic               hit3;
  logic [8:0]         row3;
  logic [8:0]         px3;
  logic [2:0]         bit3;

  // Combinational values
  logic signed [12:0] xe, ye, pwe, phe, dwe, dhe, dwm1;
  logic signed [12:0] px_rot, py_rot, px_flip, py_flip;
  logic signed [18:0] py2e;
  logic [14:0]        prod;
  logic [15:0]        plot_addr;
  logic [15:0]        cmd_addr;
  logic               odd;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation    <= rppp_pkg::ROTATION_RST;
      flip_mode   <= rppp_pkg::FLIP_MODE_RST;
      panel_w     <= rppp_pkg::PANEL_W_RST;
      panel_h     <= rppp_pkg::PANEL_H_RST;
      draw_w      <= rppp_pkg::DRAW_W_RST;
      draw_h      <= rppp_pkg::DRAW_H_RST;
      page_height <= rppp_pkg::PAGE_HEIGHT_RST;
      page_index  <= rppp_pkg::PAGE_INDEX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rppp_pkg::REG_ROTATION:    rotation    <= cfg_data[1:0];
        rppp_pkg::REG_FLIP_MODE:   flip_mode   <= cfg_data[1:0];
        rppp_pkg::REG_PANEL_W:     panel_w     <= cfg_data;
        rppp_pkg::REG_PANEL_H:     panel_h     <= cfg_data;
        rppp_pkg::REG_DRAW_W:      draw_w      <= cfg_data;
        rppp_pkg::REG_DRAW_H:      draw_h      <= cfg_data;
        rppp_pkg::REG_PAGE_HEIGHT: page_height <= cfg_data;
        rppp_pkg::REG_PAGE_INDEX:  page_index  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= take;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign inflight = 3'({2'b0, v0} + {2'b0, v1} + {2'b0, v2} + {2'b0, v3});

  // Widen coordinates and registers to signed form
  assign xe   = {{2{x0[10]}}, x0};
  assign ye   = {{2{y0[10]}}, y0};
  assign pwe  = $signed({4'b0, panel_w});
  assign phe  = $signed({4'b0, panel_h});
  assign dwe  = $signed({4'b0, draw_w});
  assign dhe  = $signed({4'b0, draw_h});
  assign dwm1 = dwe - 13'sd1;
  assign odd  = rotation[0];

  // Rotate by quarter turns
  always_comb begin
    case (rotation)
      2'd0: begin
        px_rot = xe;
        py_rot = ye;
      end
      2'd1: begin
        px_rot = pwe - ye - 13'(rppp_pkg::ROT_OFFSET);
        py_rot = xe;
      end
      2'd2: begin
        px_rot = pwe - xe - 13'(rppp_pkg::ROT_OFFSET);
        py_rot = phe - 13'sd1 - ye;
      end
      default: begin
        px_rot = ye;
        py_rot = phe - 13'sd1 - xe;
      end
    endcase
  end

  // Mirror against the drawing area
  always_comb begin
    px_flip = px1;
    py_flip = py1;
    if ((flip_mode[0] && !odd) || (flip_mode[1] && odd)) begin
      px_flip = dwe - px1;
    end
    if ((flip_mode[0] && odd) || (flip_mode[1] && !odd)) begin
      py_flip = dhe - py1;
    end
  end

  assign py2e = {{6{py2[12]}}, py2};

  // Advance the stages
  always_ff @(posedge clk) begin
    // capture the accepted word
    if (take) begin
      c0 <= '{cmd: cmd, color: pixel_color, baddr: byte_address,
              black: black_in, red: red_in};
      x0 <= x_coord;
      y0 <= y_coord;
    end
    // rotate, find the page top row
    c1   <= c0;
    px1  <= px_rot;
    py1  <= py_rot;
    top1 <= 17'(page_index) * 17'(page_height);
    // flip, find the page bottom row
    c2      <= c1;
    px2     <= px_flip;
    py2     <= py_flip;
    top2    <= $signed({2'b0, top1});
    bottom2 <= $signed({2'b0, top1}) + $signed({10'b0, page_height}) - 19'sd1;
    // test page bounds, invert the row
    c3   <= c2;
    hit3 <= (py2e >= top2) && (py2e <= bottom2) && (px2 >= 13'sd0) && (px2 <= dwm1);
    row3 <= 9'(bottom2 - py2e);
    px3  <= px2[8:0];
    bit3 <= ~px2[2:0];
  end

  // Form the byte address and classify
  assign prod      = 15'(row3) * 15'(panel_w[8:3]);
  assign plot_addr = 16'(prod) + 16'(px3[8:3]);
  assign cmd_addr  = 16'(c3.baddr);

  always_comb begin
    push_item.bit_pos = bit3;
    push_item.color   = c3.color;
    push_item.black   = c3.black;
    push_item.red     = c3.red;
    push_item.op      = rppp_pkg::OP_NONE;
    push_item.addr    = cmd_addr[rppp_pkg::ADDR_W-1:0];
    case (c3.cmd)
      rppp_pkg::CMD_PLOT: begin
        push_item.addr = plot_addr[rppp_pkg::ADDR_W-1:0];
        if (hit3 && plot_addr < 16'(rppp_pkg::BUFFER_BYTES)) begin
          push_item.op = rppp_pkg::OP_PLOT;
        end
      end
      rppp_pkg::CMD_READ: begin
        if (cmd_addr < 16'(rppp_pkg::BUFFER_BYTES)) begin
          push_item.op = rppp_pkg::OP_READ;
        end
      end
      rppp_pkg::CMD_WRITE: begin
        if (cmd_addr < 16'(rppp_pkg::BUFFER_BYTES)) begin
          push_item.op = rppp_pkg::OP_WRITE;
        end
      end
      default: ;
    endcase
  end

  assign push = v3;

endmodule
`default_nettype wire

### design/rppp_back.sv
`default_nettype none
module rppp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rppp_pkg::q_status_t q_status,
  input  wire rppp_pkg::item_t     head,
  output logic                     pop,
  output logic                     done,
  output logic [7:0]               black_out,
  output logic [7:0]               red_out,
  output logic                     in_page
);

  rppp_pkg::bk_state_t           state, state_next;
  rppp_pkg::item_t               cur;
  logic                          we;
  logic [rppp_pkg::ADDR_W-1:0]   addr;
  logic [7:0]                    black_wdata, red_wdata;
  logic [7:0]                    black_rdata, red_rdata;
  logic [7:0]                    onehot;
  logic [7:0]                    black_mod, red_mod;

  rppp_ram #(.WIDTH(8), .DEPTH(rppp_pkg::BUFFER_BYTES)) u_black (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (black_wdata),
    .rdata (black_rdata)
  );

  rppp_ram #(.WIDTH(8), .DEPTH(rppp_pkg::BUFFER_BYTES)) u_red (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (red_wdata),
    .rdata (red_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rppp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the word being executed
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Set the pixel bit in each plane
  assign onehot    = 8'b1 << cur.bit_pos;
  assign black_mod = (black_rdata & ~onehot) | (cur.color[0] ? onehot : 8'h00);
  assign red_mod   = (red_rdata & ~onehot) | (cur.color[1] ? onehot : 8'h00);

  // Next state, memory port and result
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    we          = 1'b0;
    addr        = head.addr;
    black_wdata = head.black;
    red_wdata   = head.red;
    done        = 1'b0;
    black_out   = 8'h00;
    red_out     = 8'h00;
    in_page     = 1'b0;
    case (state)
      rppp_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          we         = (head.op == rppp_pkg::OP_WRITE);
          state_next = rppp_pkg::BK_FINISH;
        end
      end
      rppp_pkg::BK_FINISH: begin
        addr        = cur.addr;
        black_wdata = black_mod;
        red_wdata   = red_mod;
        done        = 1'b1;
        state_next  = rppp_pkg::BK_IDLE;
        case (cur.op)
          rppp_pkg::OP_PLOT: begin
            we        = 1'b1;
            black_out = black_mod;
            red_out   = red_mod;
            in_page   = 1'b1;
          end
          rppp_pkg::OP_READ: begin
            black_out = black_rdata;
            red_out   = red_rdata;
          end
          default: ;
        endcase
      end
      default: state_next = rppp_pkg::BK_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // a result always follows the pop of its word
  assert property (@(posedge clk) disable iff (rst) done |-> $past(pop))
    else $error("result without a popped word");
  // results never come in back-to-back cycles
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results in back-to-back cycles");
  // a plot hit is only flagged on a result
  assert property (@(posedge clk) disable iff (rst) in_page |-> done)
    else $error("in_page without a result");
`endif

endmodule
`default_nettype wire

### design/rotated_paged_pixel_plotter.sv
`default_nettype none
// Pixel plotter for one page of a two-plane (black, red) e-paper frame buffer.
// Items: start and busy form the command channel; a word is taken at a rising
// edge with start high and busy low. cmd selects plot, read byte or write byte.
// Plots are rotated and flipped per the configuration, dropped outside the page,
// drawing width or buffer, and set one bit per plane by read-modify-write.
// Results: one per item, shown for a single cycle with done high, in order.
// The receiver cannot stall; none is needed since results are never held.
// Path: the 4-stage address front, then the queue, then the back, which pops a
// word and shows its result from the registered finish state.
// Queue: the back takes no new word before the last is finished, set by the
// single-port read-modify-write of the plane memories; the 8-word queue absorbs
// bursts and busy rises when queued plus in-flight words fill it.
// Configuration: cfg_valid, cfg_ready (always high), cfg_index, cfg_data; write
// only while the block is idle.
// Reset: rst is synchronous; it restores register defaults and empties the
// pipeline and queue. Plane contents are undefined until written.
module rotated_paged_pixel_plotter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [10:0] x_coord,
  input  wire logic signed [10:0] y_coord,
  input  wire logic [1:0]         pixel_color,
  input  wire logic [9:0]         byte_address,
  input  wire logic [7:0]         black_in,
  input  wire logic [7:0]         red_in,
  output logic                    done,
  output logic [7:0]              black_out,
  output logic [7:0]              red_out,
  output logic                    in_page
);

  logic                          take;
  logic                          q_push;
  logic                          q_pop;
  rppp_pkg::item_t               q_in;
  rppp_pkg::item_t               q_head;
  rppp_pkg::q_status_t           q_status;
  logic [2:0]                    inflight;
  logic [rppp_pkg::QCNT_W:0]     reserved;

  // Count queue slots held by stored and in-flight words
  assign reserved  = (rppp_pkg::QCNT_W + 1)'(q_status.count)
                   + (rppp_pkg::QCNT_W + 1)'(inflight);
  assign busy      = rst || (reserved >= (rppp_pkg::QCNT_W + 1)'(rppp_pkg::QUEUE_DEPTH));
  assign take      = start && !busy;
  assign cfg_ready = 1'b1;

  rppp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .cmd          (cmd),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .pixel_color  (pixel_color),
    .byte_address (byte_address),
    .black_in     (black_in),
    .red_in       (red_in),
    .push         (q_push),
    .push_item    (q_in),
    .inflight     (inflight)
  );

  rppp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  rppp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (q_head),
    .pop       (q_pop),
    .done      (done),
    .black_out (black_out),
    .red_out   (red_out),
    .in_page   (in_page)
  );

`ifndef SYNTHESIS
  // the slot reservation keeps the queue from overflowing
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_status.full)
    else $error("push into a full queue");
  // stored plus in-flight words never exceed the queue depth
  assert property (@(posedge clk) disable iff (rst)
    reserved <= (rppp_pkg::QCNT_W + 1)'(rppp_pkg::QUEUE_DEPTH))
    else $error("queue over-reserved");
`endif

endmodule
`default_nettype wire
